>>> design/mipd_pkg.sv
// Shared types and constants for the mip chain box downsampler.
// No dependencies; imported by every module of the block.
package mipd_pkg;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_SRC_WIDTH   = 3'd0,
    REG_SRC_HEIGHT  = 3'd1,
    REG_LEVEL_COUNT = 3'd2,
    REG_MIN_DIM     = 3'd3,
    REG_SOLID       = 3'd4,
    REG_TRANSPARENT = 3'd5
  } reg_idx_e;

  // back-end sequencer states
  typedef enum logic {
    ST_READ = 1'b0,
    ST_EMIT = 1'b1
  } eng_state_e;

  localparam int unsigned PIX_W    = 32;
  localparam int unsigned PAIR_W   = 36;
  localparam int unsigned CFG_W    = 13;
  localparam int unsigned HGT_W    = 13;
  localparam int unsigned ROW_W    = 12;
  localparam int unsigned MAX_HGT  = 4096;
  localparam int unsigned SOLID_TH = 8;
  localparam int unsigned OUT_W    = 64;

  typedef logic [PIX_W-1:0]  pix_t;
  typedef logic [PAIR_W-1:0] pair_t;

  // blend codes and restart pulse toward the back end
  typedef struct packed {
    logic       restart;
    logic [7:0] solid;
    logic [7:0] transparent;
  } codes_t;

  // sum of two pixels into four 9-bit fields
  function automatic pair_t pair_of(input pix_t a, input pix_t b);
    pair_t s;
    for (int i = 0; i < 4; i++) begin
      s[9*i +: 9] = {1'b0, a[8*i +: 8]} + {1'b0, b[8*i +: 8]};
    end
    return s;
  endfunction

endpackage

>>> design/mipd_front.sv
// Input side: two-entry queue that takes level-0 pixel beats.
// Depends on mipd_pkg.
module mipd_front
  import mipd_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  pix_t in_pix_i,
  output logic q_valid_o,
  output pix_t q_pix_o,
  input  logic q_pop_i
);

  pix_t       slot_q [2];
  logic       rd_q, wr_q;
  logic [1:0] cnt_q;
  logic       push;

  assign in_ready_o = (cnt_q != 2'd2);
  assign push       = in_valid_i && in_ready_o;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_pix_o    = slot_q[rd_q];

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q  <= 1'b0;
      wr_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (q_pop_i) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop_i};
    end
  end

  // payload slots
  always_ff @(posedge clk_i) begin
    if (push) slot_q[wr_q] <= in_pix_i;
  end

endmodule

>>> design/mipd_chain.sv
// Configuration registers and the derived level chain (sizes, active flags).
// Depends on mipd_pkg.
module mipd_chain
  import mipd_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_LEVELS = 8
) (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  logic                                         cfg_we_i,
  input  logic [2:0]                                   cfg_idx_i,
  input  logic [CFG_W-1:0]                             cfg_data_i,
  output logic [MAX_LEVELS-1:0]                        active_o,
  output logic [MAX_LEVELS-1:0][$clog2(MAX_WIDTH+1)-1:0] lvl_w_o,
  output logic [MAX_LEVELS-1:0][HGT_W-1:0]             lvl_h_o,
  output codes_t                                       codes_o
);

  localparam int unsigned WW = $clog2(MAX_WIDTH+1);

  logic [10:0] src_w_q;
  logic [12:0] src_h_q;
  logic [3:0]  lvl_cnt_q;
  logic [9:0]  min_dim_q;
  logic [7:0]  solid_q, transp_q;
  logic        restart_q;

  logic [WW-1:0]    w0;
  logic [HGT_W-1:0] h0;
  logic [4:0]       lc;
  logic [9:0]       mn;

  // register writes, restart pulse on any known index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_w_q   <= 11'd256;
      src_h_q   <= 13'd256;
      lvl_cnt_q <= 4'd8;
      min_dim_q <= 10'd1;
      solid_q   <= 8'd1;
      transp_q  <= 8'd0;
      restart_q <= 1'b0;
    end else begin
      restart_q <= 1'b0;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_SRC_WIDTH:   begin src_w_q   <= cfg_data_i[10:0]; restart_q <= 1'b1; end
          REG_SRC_HEIGHT:  begin src_h_q   <= cfg_data_i[12:0]; restart_q <= 1'b1; end
          REG_LEVEL_COUNT: begin lvl_cnt_q <= cfg_data_i[3:0];  restart_q <= 1'b1; end
          REG_MIN_DIM:     begin min_dim_q <= cfg_data_i[9:0];  restart_q <= 1'b1; end
          REG_SOLID:       begin solid_q   <= cfg_data_i[7:0];  restart_q <= 1'b1; end
          REG_TRANSPARENT: begin transp_q  <= cfg_data_i[7:0];  restart_q <= 1'b1; end
          default: ;
        endcase
      end
    end
  end

  // clamped base values
  always_comb begin
    if (src_w_q == 11'd0) w0 = WW'(1);
    else if (32'(src_w_q) > MAX_WIDTH) w0 = WW'(MAX_WIDTH);
    else w0 = WW'(src_w_q);
    if (src_h_q == 13'd0) h0 = HGT_W'(1);
    else if (32'(src_h_q) > MAX_HGT) h0 = HGT_W'(MAX_HGT);
    else h0 = src_h_q;
    if (lvl_cnt_q == 4'd0) lc = 5'd1;
    else if (32'(lvl_cnt_q) > MAX_LEVELS) lc = 5'(MAX_LEVELS);
    else lc = {1'b0, lvl_cnt_q};
    mn = (min_dim_q == 10'd0) ? 10'd1 : min_dim_q;
  end

  // level sizes are shifts of the base; active flags chain downward
  always_comb begin
    for (int k = 0; k < MAX_LEVELS; k++) begin
      lvl_w_o[k] = w0 >> k;
      lvl_h_o[k] = h0 >> k;
    end
    active_o[0] = 1'b1;
    for (int k = 1; k < MAX_LEVELS; k++) begin
      active_o[k] = active_o[k-1] && (32'(k) < 32'(lc)) &&
                    (32'(lvl_w_o[k]) >= 32'(mn)) && (32'(lvl_h_o[k]) >= 32'(mn));
    end
  end

  assign codes_o = '{restart: restart_q, solid: solid_q, transparent: transp_q};

endmodule

>>> design/mipd_engine.sv
// Back end: walks one pixel down the cascade, one level per read-emit step,
// with the pair-sum memory and the output register. Depends on mipd_pkg.
module mipd_engine
  import mipd_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_LEVELS = 8
) (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  logic                                         q_valid_i,
  input  pix_t                                         q_pix_i,
  output logic                                         q_pop_o,
  input  logic [MAX_LEVELS-1:0]                        active_i,
  input  logic [MAX_LEVELS-1:0][$clog2(MAX_WIDTH+1)-1:0] lvl_w_i,
  input  logic [MAX_LEVELS-1:0][HGT_W-1:0]             lvl_h_i,
  input  codes_t                                       codes_i,
  output logic                                         out_valid_o,
  input  logic                                         out_ready_i,
  output logic [OUT_W-1:0]                             out_data_o,
  output logic                                         out_last_o
);

  localparam int unsigned CW    = $clog2(MAX_WIDTH);
  localparam int unsigned LW    = $clog2(MAX_LEVELS);
  localparam int unsigned HALF  = MAX_WIDTH / 2;
  localparam int unsigned DEPTH = (MAX_LEVELS - 1) * HALF;
  localparam int unsigned AW    = $clog2(DEPTH);

  eng_state_e state_q, state_d;
  logic [LW-1:0] k_q, kn;
  pix_t          p_q;
  logic [CW-1:0]    col_q [MAX_LEVELS];
  logic [ROW_W-1:0] row_q [MAX_LEVELS];
  pix_t             hold_q [MAX_LEVELS-1];
  pair_t            mem [DEPTH];
  pair_t            rdata_q;
  logic             out_valid_q, out_last_q;
  logic [OUT_W-1:0] out_data_q;

  logic [CW-1:0]    c;
  logic [ROW_W-1:0] r;
  logic             joins, made, start, emit, can_emit, mem_we;
  logic [AW-1:0]    addr;
  pair_t            pr;
  pix_t             red_pix;
  logic [9:0]       sum [4];
  logic [31:0]      kx, cx, rx;

  assign c  = col_q[k_q];
  assign r  = row_q[k_q];
  assign kn = (32'(k_q) == MAX_LEVELS - 1) ? k_q : k_q + LW'(1);
  assign can_emit = !out_valid_q || out_ready_i;

  // does this level feed the next one
  assign joins = (32'(k_q) < MAX_LEVELS - 1) && active_i[kn] &&
                 ({1'b0, 32'(c)} < {1'b0, 32'(lvl_w_i[kn]) << 1}) &&
                 ({1'b0, 32'(r)} < {1'b0, 32'(lvl_h_i[kn]) << 1});
  assign addr  = AW'(32'(k_q) * HALF + 32'(c >> 1));

  // horizontal pair and 2x2 reduction
  always_comb begin
    pr = pair_of(hold_q[k_q[LW-1:0] == LW'(MAX_LEVELS-1) ? LW'(0) : k_q], p_q);
    for (int i = 0; i < 4; i++) begin
      sum[i] = {1'b0, rdata_q[9*i +: 9]} + {1'b0, pr[9*i +: 9]};
    end
    red_pix[7:0]   = sum[0][9:2];
    red_pix[15:8]  = sum[1][9:2];
    red_pix[23:16] = sum[2][9:2];
    red_pix[31:24] = (sum[3] >= 10'(SOLID_TH)) ? codes_i.solid : codes_i.transparent;
  end

  assign made = joins && c[0] && r[0];

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_READ: if (k_q != '0 || q_valid_i) state_d = ST_EMIT;
      ST_EMIT: if (can_emit) state_d = ST_READ;
      default: state_d = ST_READ;
    endcase
  end

  // sequencer outputs
  always_comb begin
    start   = (state_q == ST_READ) && (k_q != '0 || q_valid_i);
    q_pop_o = (state_q == ST_READ) && (k_q == '0) && q_valid_i;
    emit    = (state_q == ST_EMIT) && can_emit;
    mem_we  = emit && joins && c[0] && !r[0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_READ;
    else state_q <= state_d;
  end

  // pair-sum memory, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[addr] <= pr;
    if (start && joins) rdata_q <= mem[addr];
  end

  // level index and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q <= '0;
      for (int k = 0; k < MAX_LEVELS; k++) begin
        col_q[k] <= '0;
        row_q[k] <= '0;
      end
    end else if (codes_i.restart) begin
      k_q <= '0;
      for (int k = 0; k < MAX_LEVELS; k++) begin
        col_q[k] <= '0;
        row_q[k] <= '0;
      end
    end else if (emit) begin
      k_q <= made ? k_q + LW'(1) : '0;
      if (32'(c) + 1 >= 32'(lvl_w_i[k_q])) begin
        col_q[k_q] <= '0;
        row_q[k_q] <= (32'(r) + 1 >= 32'(lvl_h_i[k_q])) ? '0 : r + ROW_W'(1);
      end else begin
        col_q[k_q] <= c + CW'(1);
      end
    end
  end

  // current pixel and even-column hold
  always_ff @(posedge clk_i) begin
    if (q_pop_o) p_q <= q_pix_i;
    else if (emit && made) p_q <= red_pix;
    if (emit && joins && !c[0]) hold_q[k_q[LW-1:0] == LW'(MAX_LEVELS-1) ? LW'(0) : k_q] <= p_q;
  end

  // output register
  assign kx = 32'(k_q);
  assign cx = 32'(c);
  assign rx = 32'(r);
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (emit) out_valid_q <= 1'b1;
    else if (out_ready_i) out_valid_q <= 1'b0;
  end
  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_data_q <= {7'd0, p_q[31:24], p_q[23:16], p_q[15:8], p_q[7:0],
                     rx[11:0], cx[9:0], kx[2:0]};
      out_last_q <= !made;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_last_o  = out_last_q;

endmodule

>>> design/mipmap_box_downsampler.sv
// Top level of the mip chain box downsampler.
// Depends on mipd_pkg, mipd_front, mipd_chain and mipd_engine.
//
// Level-0 pixels enter on s_axis as one beat each, in raster order. For each
// pixel the block sends the level-0 echo on m_axis, then one beat for every
// level whose 2x2 block that pixel completes; tlast marks the final beat of
// the pixel. Every result beat passes the back-end sequencer's memory-read
// state, then its reduce-and-emit state. A two-beat queue takes input while
// the sequencer works. The pair-sum memory is read at most once and written
// at most once per level step. Configuration is written through
// cfg_we_i/cfg_idx_i/cfg_data_i, and the user must write it only while the
// block is idle; the block itself does not enforce this. Any known register
// write restarts all level positions.
// Reset loads the default registers and clears queue, positions and output.
// When m_axis_tready is low the output register holds its beat and the
// sequencer waits; the input queue keeps taking beats until it is full.
module mipmap_box_downsampler
  import mipd_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_LEVELS = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [31:0]       s_axis_tdata,  // red, green, blue, blend
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [OUT_W-1:0]  m_axis_tdata,  // level, pos_x, pos_y, out_red,
                                           // out_green, out_blue, out_blend, pad
  output logic              m_axis_tlast,
  input  logic              cfg_we_i,
  input  logic [2:0]        cfg_idx_i,
  input  logic [CFG_W-1:0]  cfg_data_i
);

  localparam int unsigned WW = $clog2(MAX_WIDTH+1);

  logic q_valid, q_pop;
  pix_t q_pix;
  logic [MAX_LEVELS-1:0]            active;
  logic [MAX_LEVELS-1:0][WW-1:0]    lvl_w;
  logic [MAX_LEVELS-1:0][HGT_W-1:0] lvl_h;
  codes_t codes;

  mipd_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_pix_i   (s_axis_tdata),
    .q_valid_o  (q_valid),
    .q_pix_o    (q_pix),
    .q_pop_i    (q_pop)
  );

  mipd_chain #(.MAX_WIDTH(MAX_WIDTH), .MAX_LEVELS(MAX_LEVELS)) u_chain (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .active_o (active),
    .lvl_w_o  (lvl_w),
    .lvl_h_o  (lvl_h),
    .codes_o  (codes)
  );

  mipd_engine #(.MAX_WIDTH(MAX_WIDTH), .MAX_LEVELS(MAX_LEVELS)) u_engine (
    .clk_i, .rst_ni,
    .q_valid_i   (q_valid),
    .q_pix_i     (q_pix),
    .q_pop_o     (q_pop),
    .active_i    (active),
    .lvl_w_i     (lvl_w),
    .lvl_h_i     (lvl_h),
    .codes_i     (codes),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

  // the sequencer only pops a queue that holds a beat
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid) else $error("pop from empty queue");

  // a full queue is never seen as empty
  a_full_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> q_valid) else $error("queue full but empty");

  // level zero is always active
  a_level0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active[0]) else $error("level zero inactive");

endmodule
